>>> design/fpp_pkg.sv
// Shared types, constants, the arctangent table and a saturation helper for the fisheye projection block.
package fpp_pkg;

  localparam int unsigned DefaultMaxCoefficients = 16;
  localparam int unsigned CordicSteps = 30;

  // Item kinds.
  localparam logic KIND_PROJECT = 1'b0;
  localparam logic KIND_COEF    = 1'b1;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_GAIN_C   = 3'd0;
  localparam logic [2:0] REG_SKEW_D   = 3'd1;
  localparam logic [2:0] REG_SKEW_E   = 3'd2;
  localparam logic [2:0] REG_CENTER_X = 3'd3;
  localparam logic [2:0] REG_CENTER_Y = 3'd4;
  localparam logic [2:0] REG_POLY_LEN = 3'd5;

  // Arctangent of 2^-i in Q2.30, truncated.
  function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
    logic signed [33:0] t;
    case (i)
      5'd0: t = 34'sh03243F6A8;
      5'd1: t = 34'sh01DAC6705;
      5'd2: t = 34'sh00FADBAFC;
      5'd3: t = 34'sh007F56EA6;
      5'd4: t = 34'sh003FEAB76;
      5'd5: t = 34'sh001FFD55B;
      5'd6: t = 34'sh000FFFAAA;
      5'd7: t = 34'sh0007FFF55;
      5'd8: t = 34'sh0003FFFEA;
      5'd9: t = 34'sh0001FFFFD;
      5'd10: t = 34'sh0000FFFFF;
      5'd11: t = 34'sh00007FFFF;
      5'd12: t = 34'sh00003FFFF;
      5'd13: t = 34'sh00001FFFF;
      5'd14: t = 34'sh00000FFFF;
      5'd15: t = 34'sh000007FFF;
      5'd16: t = 34'sh000003FFF;
      5'd17: t = 34'sh000001FFF;
      5'd18: t = 34'sh000000FFF;
      5'd19: t = 34'sh0000007FF;
      5'd20: t = 34'sh0000003FF;
      5'd21: t = 34'sh0000001FF;
      5'd22: t = 34'sh0000000FF;
      5'd23: t = 34'sh00000007F;
      5'd24: t = 34'sh00000003F;
      5'd25: t = 34'sh00000001F;
      5'd26: t = 34'sh00000000F;
      5'd27: t = 34'sh000000007;
      5'd28: t = 34'sh000000003;
      5'd29: t = 34'sh000000001;
      default: t = '0;
    endcase
    return t;
  endfunction

  // Saturate a 64-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Data handed from one CORDIC cell to the next.
  typedef struct packed {
    logic signed [35:0] xr;
    logic signed [35:0] yr;
    logic signed [35:0] acc;
  } fpp_vec_t;

endpackage

>>> design/fpp_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module fpp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/fpp_cordic_cell.sv
// One CORDIC vectoring cell; a row of these is stepped one cell per cycle while shift is high.
module fpp_cordic_cell
  import fpp_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic     clk,
  input  logic     load,
  input  fpp_vec_t load_vec,
  input  logic     shift,
  input  fpp_vec_t prev_vec,
  output fpp_vec_t vec
);

  fpp_vec_t vec_next;
  logic signed [35:0] dx;
  logic signed [35:0] dy;
  logic signed [33:0] tab;

  // Rotate the incoming vector towards the x axis by one micro-angle.
  always_comb begin
    dx  = prev_vec.yr >>> STEP;
    dy  = prev_vec.xr >>> STEP;
    tab = atan_entry(5'(STEP));
    if (!prev_vec.yr[35]) begin
      vec_next.xr  = prev_vec.xr + dx;
      vec_next.yr  = prev_vec.yr - dy;
      vec_next.acc = prev_vec.acc + 36'(tab);
    end else begin
      vec_next.xr  = prev_vec.xr - dx;
      vec_next.yr  = prev_vec.yr + dy;
      vec_next.acc = prev_vec.acc - 36'(tab);
    end
  end

  // Hold the cell's vector; the first cell is loaded from outside.
  always_ff @(posedge clk) begin
    if (load) begin
      vec <= load_vec;
    end else if (shift) begin
      vec <= vec_next;
    end
  end

endmodule

>>> design/fpp_cordic_row.sv
// Row of CORDIC cells that computes the elevation angle of (rho, z).
module fpp_cordic_row
  import fpp_pkg::*;
(
  input  logic     clk,
  input  logic     load,
  input  fpp_vec_t load_vec,
  input  logic     shift,
  output fpp_vec_t result
);

  fpp_vec_t chain [CordicSteps+1];

  assign chain[0] = load_vec;

  // Cell i holds the vector after i+1 micro-rotations.
  for (genvar i = 0; i < CordicSteps; i++) begin : g_cell
    fpp_cordic_cell #(.STEP(i)) u_cell (
      .clk      (clk),
      .load     (1'b0),
      .load_vec (load_vec),
      .shift    (shift || (load && i == 0)),
      .prev_vec (chain[i]),
      .vec      (chain[i+1])
    );
  end

  assign result = chain[CordicSteps];

endmodule

>>> design/fisheye_point_projection.sv
// Top level of the fisheye point projection block.
// Projects one Q16.16 point per request, or writes one polynomial coefficient.
// A coefficient write is taken whenever the block is idle. A projection
// passes through these steps on its way to the result register:
//  - squaring the coordinates (S_SQ0, S_SQ1);
//  - a bit-serial square root;
//  - a bit-serial divider for cos and sin, with the first CORDIC cell
//    loaded in the last step of the sin division;
//  - the rest of the CORDIC row, stepped one cell per cycle, and a
//    rounding step for the angle;
//  - a Horner loop that reads, multiplies and adds per table coefficient;
//  - the projection and the affine step on one shared multiplier, and
//    a final step to hand the pixel to the result register.
// A degenerate point goes from S_SQ0 straight to S_DONE.
// One item is worked on at a time, and the next request is taken in the cycle
// after the result register is loaded. The result register lets the next
// request in while the previous result waits.
module fisheye_point_projection
  import fpp_pkg::*;
#(
  parameter int unsigned MAX_COEFFICIENTS = DefaultMaxCoefficients
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic [3:0]  coef_index,
  input  logic signed [31:0] coef_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] pixel_x,
  output logic signed [31:0] pixel_y,
  output logic        degenerate
);

  localparam int unsigned AW = (MAX_COEFFICIENTS > 1) ? $clog2(MAX_COEFFICIENTS) : 1;
  localparam int unsigned RD = 1 << AW;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ0, S_SQ1, S_SQRT, S_DIVX, S_DIVY, S_CORD, S_THETA,
    S_HRD, S_HMUL, S_HADD, S_PC, S_PS, S_AX0, S_AX1, S_AY0, S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic signed [17:0] gain_c, skew_d, skew_e;
  logic [31:0] center_x, center_y;
  logic [4:0] poly_length;

  logic [2:0] reg_idx;
  assign reg_idx = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_c <= 18'sd65536;
      skew_d <= '0;
      skew_e <= '0;
      center_x <= '0;
      center_y <= '0;
      poly_length <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_GAIN_C:   gain_c <= pwdata[17:0];
        REG_SKEW_D:   skew_d <= pwdata[17:0];
        REG_SKEW_E:   skew_e <= pwdata[17:0];
        REG_CENTER_X: center_x <= pwdata;
        REG_CENTER_Y: center_y <= pwdata;
        REG_POLY_LEN: poly_length <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      REG_GAIN_C:   prdata = 32'(gain_c);
      REG_SKEW_D:   prdata = 32'(skew_d);
      REG_SKEW_E:   prdata = 32'(skew_e);
      REG_CENTER_X: prdata = center_x;
      REG_CENTER_Y: prdata = center_y;
      REG_POLY_LEN: prdata = 32'(poly_length);
      default:      prdata = '0;
    endcase
  end

  // Coefficient table.
  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0] ram_rdata;
  logic in_acc;
  assign in_acc = in_valid && !in_stall;
  assign ram_we = in_acc && kind == KIND_COEF && 32'(coef_index) < MAX_COEFFICIENTS;
  assign ram_waddr = AW'(coef_index);

  fpp_ram #(.WIDTH(32), .DEPTH(RD)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(coef_value),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // Working registers.
  logic signed [31:0] px_in, py_in, pz_in;
  logic [63:0] sq_n, sq_res, sq_bit;   // square root
  logic [31:0] rho;
  logic [62:0] div_rem;                // restoring divider
  logic [30:0] div_q;
  logic [4:0]  cnt;
  logic signed [31:0] cs, sn;
  logic signed [31:0] theta;
  logic signed [31:0] hr;              // Horner accumulator
  logic [5:0]  hk;                     // remaining coefficients
  logic signed [63:0] prod;            // shared multiplier output
  logic signed [32:0] pc, ps;
  logic signed [63:0] sumx;
  logic signed [31:0] res_x, res_y;
  logic res_deg;

  logic [5:0] len_eff;
  assign len_eff = (32'(poly_length) > MAX_COEFFICIENTS) ? 6'(MAX_COEFFICIENTS) : 6'(poly_length);
  assign ram_raddr = AW'(hk - 6'd1);

  // CORDIC row.
  logic cord_load, cord_shift;
  fpp_vec_t cord_in, cord_out;
  assign cord_in.xr  = 36'(rho);
  assign cord_in.yr  = 36'(pz_in);
  assign cord_in.acc = '0;
  fpp_cordic_row u_row (
    .clk(clk), .load(cord_load), .load_vec(cord_in), .shift(cord_shift), .result(cord_out)
  );
  assign cord_load  = (state == S_DIVY) && (cnt == 5'd0);
  assign cord_shift = (state == S_CORD);

  // Divider step: numerator magnitude << 30 over rho, one quotient bit a cycle.
  logic [62:0] div_trial;
  logic [62:0] div_rho_sh;
  always_comb begin
    div_rho_sh = 63'(rho) << cnt;
    div_trial  = div_rem - div_rho_sh;
  end

  // Shared multiplier inputs.
  logic signed [31:0] ma;
  logic signed [32:0] mb;
  assign prod = 64'(ma) * 64'(mb);

  logic signed [63:0] rnd16, rnd30;
  assign rnd16 = (prod + 64'sd32768) >>> 16;
  assign rnd30 = (prod + 64'sd536870912) >>> 30;

  always_comb begin
    ma = '0; mb = '0;
    case (state)
      S_HMUL: begin ma = hr; mb = -33'(theta); end
      S_PC:   begin ma = hr; mb = 33'(cs); end
      S_PS:   begin ma = hr; mb = 33'(sn); end
      S_AX0:  begin ma = 32'(gain_c); mb = pc; end
      S_AX1:  begin ma = 32'(skew_d); mb = ps; end
      S_AY0:  begin ma = 32'(skew_e); mb = pc; end
      default: ;
    endcase
  end

  logic [31:0] mag_x, mag_y;
  assign mag_x = px_in[31] ? 32'(-px_in) : 32'(px_in);
  assign mag_y = py_in[31] ? 32'(-py_in) : 32'(py_in);

  logic signed [63:0] hsum;
  assign hsum = 64'(hr) + 64'(signed'(ram_rdata));

  logic signed [35:0] th_r;
  assign th_r = (cord_out.acc + 36'sd8192) >>> 14;

  assign in_stall  = (state != S_IDLE);

  // Sequencer holding state and the registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc && kind == KIND_PROJECT) begin
            px_in <= point_x; py_in <= point_y; pz_in <= point_z;
            state <= S_SQ0;
          end
        end
        S_SQ0: begin
          if (px_in == 0 && py_in == 0) begin
            res_x <= '0; res_y <= '0; res_deg <= 1'b1;
            state <= S_DONE;
          end else begin
            sq_n <= 64'(mag_x) * 64'(mag_x);
            state <= S_SQ1;
          end
        end
        S_SQ1: begin
          sq_n <= sq_n + 64'(mag_y) * 64'(mag_y);
          sq_res <= '0;
          sq_bit <= 64'h4000_0000_0000_0000;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_bit == 0) begin
            rho <= sq_res[31:0];
            div_rem <= 63'(mag_x) << 30;
            div_q <= '0;
            cnt <= 5'd30;
            state <= S_DIVX;
          end else begin
            if (sq_n >= sq_res + sq_bit) begin
              sq_n <= sq_n - (sq_res + sq_bit);
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end
        S_DIVX, S_DIVY: begin
          logic [30:0] q;
          q = div_q;
          if (div_rem >= div_rho_sh) q[cnt] = 1'b1;
          if (cnt == 5'd0) begin
            if (state == S_DIVX) begin
              cs <= px_in[31] ? -32'(q) : 32'(q);
              div_rem <= 63'(mag_y) << 30;
              div_q <= '0;
              cnt <= 5'd30;
              state <= S_DIVY;
            end else begin
              sn <= py_in[31] ? -32'(q) : 32'(q);
              cnt <= 5'd0;
              state <= S_CORD;
            end
          end else begin
            if (div_rem >= div_rho_sh) div_rem <= div_trial;
            div_q <= q;
            cnt <= cnt - 5'd1;
          end
        end
        S_CORD: begin
          if (cnt == 5'(CordicSteps - 2)) state <= S_THETA;
          cnt <= cnt + 5'd1;
        end
        S_THETA: begin
          theta <= th_r[31:0];
          hr <= '0;
          hk <= len_eff;
          state <= (len_eff == 0) ? S_PC : S_HRD;
        end
        S_HRD: state <= S_HMUL;
        S_HMUL: begin
          hr <= sat32(rnd16);
          state <= S_HADD;
        end
        S_HADD: begin
          hr <= sat32(hsum);
          hk <= hk - 6'd1;
          state <= (hk == 6'd1) ? S_PC : S_HRD;
        end
        S_PC: begin
          pc <= rnd30[32:0];
          state <= S_PS;
        end
        S_PS: begin
          ps <= rnd30[32:0];
          state <= S_AX0;
        end
        S_AX0: begin
          sumx <= prod;
          state <= S_AX1;
        end
        S_AX1: begin
          res_x <= sat32(((sumx + prod + 64'sd32768) >>> 16)
                         + $signed(64'(center_x)));
          state <= S_AY0;
        end
        S_AY0: begin
          res_y <= sat32(((prod + (64'(ps) <<< 16) + 64'sd32768) >>> 16)
                         + $signed(64'(center_y)));
          res_deg <= 1'b0;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            pixel_x <= res_x; pixel_y <= res_y; degenerate <= res_deg;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sim/fisheye_point_projection_test.sv
// Self-checking testbench for the fisheye point projection block.
`timescale 1ns / 1ps

module fisheye_point_projection_test;
  import fpp_pkg::*;

  localparam int unsigned NumCoefs = 16;
  localparam int unsigned RandomItems = 1030;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = KIND_PROJECT;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic signed [31:0] point_z = '0;
  logic [3:0] coef_index = '0;
  logic signed [31:0] coef_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] pixel_x;
  logic signed [31:0] pixel_y;
  logic degenerate;

  fisheye_point_projection uut (.*);

  always #5 clk = ~clk;

  // One projected pixel as the block should return it.
  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic deg;
  } pixel_t;

  // One row of the directed table; check_fixed marks a typed-in result.
  typedef struct {
    logic k;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [3:0] idx;
    logic signed [31:0] val;
    logic check_fixed;
    pixel_t fixed;
  } request_t;

  // Predictor state: its own copy of the registers and the coefficient table.
  logic signed [17:0] mdl_c, mdl_d, mdl_e;
  logic [31:0] mdl_cx, mdl_cy;
  logic [4:0] mdl_len;
  logic signed [31:0] mdl_coef [NumCoefs];

  pixel_t pending_pixels[$];
  int unsigned errors = 0;
  int unsigned pixels_seen = 0;
  int unsigned requests_sent = 0;
  int unsigned idle_cycles = 0;
  bit quiet_phase = 1'b0;
  bit hold_off = 1'b0;

  // Rounding right shift on 64 bits: add half an LSB, then floor.
  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Square root of a 64-bit unsigned value, floored.
  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Arctangent in Q2.30, truncated, for CORDIC step i.
  function automatic longint atan_step(int i);
    longint tab [30] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
      64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003, 64'h00000001};
    return tab[i];
  endfunction

  // Direction component in Q2.30, truncated toward zero.
  function automatic longint unit_q30(longint num, longint unsigned den);
    longint unsigned mag;
    longint q;
    mag = (num < 0) ? longint'(-num) : num;
    q = longint'((mag << 30) / den);
    return (num < 0) ? -q : q;
  endfunction

  // Works out the pixel for one point with the current lens settings.
  function automatic pixel_t project_point(longint x, longint y, longint z);
    pixel_t p;
    longint unsigned rho;
    longint cs, sn, xr, yr, acc, dx, dy, theta, v, r, pc, ps;
    int len;
    p.deg = 1'b0;
    if (x == 0 && y == 0) begin
      p.px = '0;
      p.py = '0;
      p.deg = 1'b1;
      return p;
    end
    rho = root64(longint'(x * x) + longint'(y * y));
    cs = unit_q30(x, rho);
    sn = unit_q30(y, rho);
    xr = rho;
    yr = z;
    acc = 0;
    for (int i = 0; i < 30; i++) begin
      dx = yr >>> i;
      dy = xr >>> i;
      if (yr >= 0) begin
        xr += dx; yr -= dy; acc += atan_step(i);
      end else begin
        xr -= dx; yr += dy; acc -= atan_step(i);
      end
    end
    theta = round_shift(acc, 14);
    v = -theta;
    len = (mdl_len > NumCoefs) ? NumCoefs : mdl_len;
    r = 0;
    for (int k = 0; k < len; k++) begin
      r = clamp32(round_shift(r * v, 16));
      r = clamp32(r + longint'(mdl_coef[len - 1 - k]));
    end
    pc = round_shift(r * cs, 30);
    ps = round_shift(r * sn, 30);
    p.px = 32'(clamp32(round_shift(longint'(mdl_c) * pc + longint'(mdl_d) * ps, 16)
                       + longint'(mdl_cx)));
    p.py = 32'(clamp32(round_shift(longint'(mdl_e) * pc + ps * 65536, 16)
                       + longint'(mdl_cy)));
    return p;
  endfunction

  // Register write over the configuration port, mirrored into the predictor.
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_GAIN_C:   mdl_c = value[17:0];
      REG_SKEW_D:   mdl_d = value[17:0];
      REG_SKEW_E:   mdl_e = value[17:0];
      REG_CENTER_X: mdl_cx = value;
      REG_CENTER_Y: mdl_cy = value;
      REG_POLY_LEN: mdl_len = value[4:0];
      default: ;
    endcase
  endtask

  // Stops offering, waits until every expected pixel has come back, then
  // lets the block settle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Offers one request, with a random gap first, and waits for acceptance.
  // The request stays on the port until the next one replaces it or the
  // sender goes idle.
  task automatic send_request(request_t rq);
    pixel_t p;
    while (!quiet_phase && $urandom_range(99) < 21) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    kind <= rq.k;
    point_x <= rq.x; point_y <= rq.y; point_z <= rq.z;
    coef_index <= rq.idx; coef_value <= rq.val;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    if (rq.k == KIND_COEF) begin
      mdl_coef[rq.idx] = rq.val;
    end else begin
      p = project_point(rq.x, rq.y, rq.z);
      if (rq.check_fixed) p = rq.fixed;
      pending_pixels.insert(pending_pixels.size(), p);
    end
  endtask

  function automatic request_t coef_req(int idx, logic signed [31:0] val);
    request_t rq;
    rq = '{KIND_COEF, 0, 0, 0, idx[3:0], val, 1'b0, '{0, 0, 1'b0}};
    return rq;
  endfunction

  function automatic request_t point_req(logic signed [31:0] x, logic signed [31:0] y,
                                         logic signed [31:0] z);
    request_t rq;
    rq = '{KIND_PROJECT, x, y, z, 4'($urandom()), $urandom(), 1'b0, '{0, 0, 1'b0}};
    return rq;
  endfunction

  // Random coordinate: modest magnitudes half the time, else full range, zero or an extreme.
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'sd0;
      2: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return $signed($urandom_range(32'h00A00000)) - 32'sh00500000;
    endcase
  endfunction

  // Response checking and the idle watchdog.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
        $display("FAIL fisheye_point_projection");
        $finish;
      end
      if (out_valid && !out_stall) begin
        pixels_seen <= pixels_seen + 1;
        if (pending_pixels.size() == 0) begin
          $error("pixel with no request waiting");
          errors++;
        end else begin
          want = pending_pixels.pop_front();
          if (pixel_x !== want.px) begin
            $error("pixel_x expected %0d actual %0d", want.px, pixel_x);
            errors++;
          end
          if (pixel_y !== want.py) begin
            $error("pixel_y expected %0d actual %0d", want.py, pixel_y);
            errors++;
          end
          if (degenerate !== want.deg) begin
            $error("degenerate expected %0d actual %0d", want.deg, degenerate);
            errors++;
          end
        end
      end
    end
  end

  // Receiver stalls: random, none during the quiet phase, long on hold-off.
  always @(negedge clk) begin
    if (rst || quiet_phase) out_stall <= 1'b0;
    else if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < 21);
  end

  // Long receiver hold-off, counted here, while requests keep coming.
  initial begin
    wait (requests_sent == 300);
    hold_off = 1'b1;
    repeat (2000) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    request_t table_rows[$];
    request_t rq;
    int idx;
    mdl_c = 18'sd65536; mdl_d = '0; mdl_e = '0;
    mdl_cx = '0; mdl_cy = '0; mdl_len = '0;
    foreach (mdl_coef[i]) mdl_coef[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: degenerate point and zero-length polynomial after reset.
    rq = point_req(0, 0, 32'sh7FFFFFFF);
    rq.check_fixed = 1'b1; rq.fixed = '{0, 0, 1'b1};
    table_rows.insert(table_rows.size(), rq);
    rq = point_req(32'sh00010000, 0, 0);
    rq.check_fixed = 1'b1; rq.fixed = '{0, 0, 1'b0};
    table_rows.insert(table_rows.size(), rq);
    // Fill every slot, extremes in some, then overwrite the top slot.
    for (int i = 0; i < 16; i++)
      table_rows.insert(table_rows.size(),
                        coef_req(i, (i == 0) ? 32'sh7FFFFFFF :
                                    (i == 1) ? 32'sh80000000 : $urandom()));
    table_rows.insert(table_rows.size(), coef_req(15, 32'sh00008000));
    table_rows.insert(table_rows.size(),
                      point_req(32'sh80000000, 32'sh80000000, 32'sh80000000));
    table_rows.insert(table_rows.size(),
                      point_req(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
    table_rows.insert(table_rows.size(), point_req(32'sh80000000, 0, 32'sh7FFFFFFF));
    table_rows.insert(table_rows.size(), point_req(0, -1, 32'sh80000000));
    foreach (table_rows[i]) send_request(table_rows[i]);
    wait_idle();

    // Settings phases, covering extremes of every register.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_GAIN_C, 32'h1FFFF); write_reg(REG_SKEW_D, 32'h20000);
          write_reg(REG_SKEW_E, 32'h1FFFF); write_reg(REG_CENTER_X, 32'hFFFFFFFF);
          write_reg(REG_CENTER_Y, 32'h0); write_reg(REG_POLY_LEN, 5'd31);
        end
        1: begin
          write_reg(REG_GAIN_C, 32'h20000); write_reg(REG_SKEW_D, 32'h1FFFF);
          write_reg(REG_SKEW_E, 32'h20000); write_reg(REG_CENTER_X, 32'h0);
          write_reg(REG_CENTER_Y, 32'hFFFFFFFF); write_reg(REG_POLY_LEN, 5'd16);
        end
        2: begin
          write_reg(REG_GAIN_C, 32'h10000); write_reg(REG_SKEW_D, 32'h0);
          write_reg(REG_SKEW_E, 32'h0); write_reg(REG_CENTER_X, 32'h01400000);
          write_reg(REG_CENTER_Y, 32'h00F00000); write_reg(REG_POLY_LEN, 5'd4);
        end
        3: write_reg(REG_POLY_LEN, 5'd0);
        default: begin
          write_reg(REG_GAIN_C, $urandom()); write_reg(REG_SKEW_D, $urandom());
          write_reg(REG_SKEW_E, $urandom()); write_reg(REG_CENTER_X, $urandom());
          write_reg(REG_CENTER_Y, $urandom()); write_reg(REG_POLY_LEN, $urandom_range(1, 17));
        end
      endcase
      quiet_phase = (ph == 2);
      for (int n = 0; n < RandomItems / 6; n++) begin
        if ($urandom_range(9) == 0) begin
          idx = $urandom_range(15);
          send_request(coef_req(idx, $urandom_range(3) == 0 ? $urandom() :
                                     $signed($urandom_range(32'h20000)) - 32'sh10000));
        end else begin
          send_request(point_req(rand_coord(), rand_coord(), rand_coord()));
        end
      end
      quiet_phase = 1'b0;
      wait_idle();
    end

    $display("Sent %0d requests over seven settings; %0d pixels checked.",
             requests_sent, pixels_seen);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("PASS fisheye_point_projection");
    end else begin
      $display("FAIL fisheye_point_projection");
    end
    $finish;
  end

endmodule
